@@ rtl/core/utf8dv_pkg.sv @@
// types, constants and lead byte decoding shared by the utf-8 decoder
`default_nettype none

package utf8dv_pkg;

  localparam int unsigned CP_W    = 21;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned QDEPTH  = 3;
  localparam int unsigned QPTR_W  = 2;

  localparam logic [CP_W-1:0] REPLACEMENT_CHAR = 21'h00FFFD;

  localparam logic KIND_VALID   = 1'b0;
  localparam logic KIND_INVALID = 1'b1;

  localparam logic [7:0] ASCII_MAX    = 8'h7F;
  localparam logic [7:0] LEAD2_MIN    = 8'hC0;
  localparam logic [7:0] LEAD2_BAD    = 8'hC1;
  localparam logic [7:0] LEAD3_MIN    = 8'hE0;
  localparam logic [7:0] LEAD4_MIN    = 8'hF0;
  localparam logic [7:0] LEAD_LIMIT   = 8'hF5;
  localparam logic [7:0] CONT_MIN     = 8'h80;
  localparam logic [7:0] CONT_MIN_E0  = 8'hA0;
  localparam logic [7:0] CONT_EDGE_F  = 8'h90;

  typedef struct packed {
    logic            kind;
    logic [CP_W-1:0] code_point;
    logic [CNT_W-1:0] byte_count;
    logic            last;
  } result_t;

  typedef struct packed {
    logic             emit;
    result_t          res;
    logic [CP_W-1:0]  pv;
    logic [CNT_W-1:0] expected;
    logic [CNT_W-1:0] seen;
  } start_t;

  // handle one byte from a clean decoder state
  function automatic start_t start_byte(input logic [7:0] c);
    start_t s;
    s.emit            = 1'b0;
    s.res.kind        = KIND_VALID;
    s.res.code_point  = {{(CP_W-8){1'b0}}, c};
    s.res.byte_count  = 3'd1;
    s.res.last        = 1'b1;
    s.pv              = '0;
    s.expected        = 3'd0;
    s.seen            = 3'd0;
    if (c <= ASCII_MAX) begin
      s.emit     = 1'b1;
      s.pv       = {{(CP_W-8){1'b0}}, c};
      s.expected = 3'd1;
      s.seen     = 3'd1;
    end else if (c >= LEAD_LIMIT || c == LEAD2_BAD || c < LEAD2_MIN) begin
      s.emit           = 1'b1;
      s.res.kind       = KIND_INVALID;
      s.res.code_point = REPLACEMENT_CHAR;
    end else if (c >= LEAD4_MIN) begin
      s.seen     = 3'd1;
      s.expected = 3'd4;
      s.pv       = {{(CP_W-3){1'b0}}, c[2:0]};
    end else if (c >= LEAD3_MIN) begin
      s.seen     = 3'd1;
      s.expected = 3'd3;
      s.pv       = {{(CP_W-4){1'b0}}, c[3:0]};
    end else begin
      s.seen     = 3'd1;
      s.expected = 3'd2;
      s.pv       = {{(CP_W-5){1'b0}}, c[4:0]};
    end
    return s;
  endfunction

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] n;
    n = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
    return n;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/utf8_stream_decoder_validator_top.sv @@
// utf-8 byte stream decoder and validator, top level
//
// in channel: one byte per item on data_byte, in_valid / in_ready.
// out channel: one result per item on result_kind, code_point, byte_count,
// last_of_run, out_valid / out_ready. a byte gives zero, one or two results;
// last_of_run marks the final result caused by a byte.
// a result is queued the cycle after its byte is accepted. throughput is one
// byte per cycle while the queue holds at most one result, set by the single decode stage
// and the three-entry result queue behind it; a byte is taken whenever the
// queue holds at most one result, so a byte that gives two results while the
// receiver waits holds off input until the queue drains.
// a broken sequence is reported as U+FFFD with the count of bytes it covered,
// then the current byte is decoded from a clean state.
// reset clears the decoder to idle and empties the queue; in_ready is high
// once reset has cleared the queue. while the receiver stalls, queued results
// hold in place and input stops once two results are waiting.
`default_nettype none

module utf8_stream_decoder_validator_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             result_kind,
  output logic [20:0]      code_point,
  output logic [2:0]       byte_count,
  output logic             last_of_run
);

  // decoder state
  logic [utf8dv_pkg::CP_W-1:0]  partial_value, partial_value_next;
  logic [utf8dv_pkg::CNT_W-1:0] bytes_expected, bytes_expected_next;
  logic [utf8dv_pkg::CNT_W-1:0] bytes_seen, bytes_seen_next;

  // result queue
  utf8dv_pkg::result_t            q [utf8dv_pkg::QDEPTH];
  logic [utf8dv_pkg::QPTR_W-1:0]  head, head_next;
  logic [utf8dv_pkg::QPTR_W-1:0]  tail;
  logic [1:0]                     count, count_next;

  utf8dv_pkg::result_t res_a, res_b;
  utf8dv_pkg::start_t  sb;
  logic [1:0]          n_res;
  logic                accept, pop, idle, cont, broken;
  logic [utf8dv_pkg::CNT_W-1:0] seen_inc;
  logic [utf8dv_pkg::CP_W-1:0]  pv_ext;

  assign accept   = in_valid && in_ready;
  assign pop      = out_valid && out_ready;
  assign in_ready = (count <= 2'd1);
  assign out_valid = (count != 2'd0);
  assign tail     = (count == 2'd0) ? head : utf8dv_pkg::ptr_inc(head);

  assign idle     = (bytes_seen == bytes_expected);
  assign cont     = (data_byte[7:6] == 2'b10);
  assign seen_inc = bytes_seen + 3'd1;
  assign pv_ext   = {partial_value[utf8dv_pkg::CP_W-7:0], data_byte[5:0]};
  assign sb       = utf8dv_pkg::start_byte(data_byte);

  // overlong, out of range and missing continuation checks
  always_comb begin
    broken = !cont;
    if (cont && bytes_seen == 3'd1) begin
      if (bytes_expected == 3'd4 && partial_value == 21'd4 &&
          data_byte >= utf8dv_pkg::CONT_EDGE_F)
        broken = 1'b1;
      if (partial_value == '0) begin
        if (bytes_expected == 3'd3 && data_byte < utf8dv_pkg::CONT_MIN_E0)
          broken = 1'b1;
        if (bytes_expected == 3'd4 && data_byte < utf8dv_pkg::CONT_EDGE_F)
          broken = 1'b1;
        if (bytes_expected == 3'd2 && data_byte != utf8dv_pkg::CONT_MIN)
          broken = 1'b1;
      end
    end
  end

  always_comb begin
    partial_value_next  = partial_value;
    bytes_expected_next = bytes_expected;
    bytes_seen_next     = bytes_seen;
    n_res               = 2'd0;
    res_a               = sb.res;
    res_b               = sb.res;
    if (idle || broken) begin
      partial_value_next  = sb.pv;
      bytes_expected_next = sb.expected;
      bytes_seen_next     = sb.seen;
      if (!idle) begin
        // report the sequence so far, then the byte from a clean state
        res_a.kind       = utf8dv_pkg::KIND_INVALID;
        res_a.code_point = utf8dv_pkg::REPLACEMENT_CHAR;
        res_a.byte_count = bytes_seen;
        res_a.last       = !sb.emit;
        n_res            = sb.emit ? 2'd2 : 2'd1;
      end else begin
        n_res = sb.emit ? 2'd1 : 2'd0;
      end
    end else begin
      partial_value_next = pv_ext;
      bytes_seen_next    = seen_inc;
      if (seen_inc == bytes_expected) begin
        res_a.kind       = utf8dv_pkg::KIND_VALID;
        res_a.code_point = pv_ext;
        res_a.byte_count = bytes_expected;
        res_a.last       = 1'b1;
        n_res            = 2'd1;
      end
    end
  end

  always_comb begin
    head_next  = pop ? utf8dv_pkg::ptr_inc(head) : head;
    count_next = count + (accept ? n_res : 2'd0) - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value  <= '0;
      bytes_expected <= '0;
      bytes_seen     <= '0;
      head           <= '0;
      count          <= '0;
    end else begin
      if (accept) begin
        partial_value  <= partial_value_next;
        bytes_expected <= bytes_expected_next;
        bytes_seen     <= bytes_seen_next;
      end
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && n_res != 2'd0) begin
      q[tail] <= res_a;
      if (n_res == 2'd2)
        q[utf8dv_pkg::ptr_inc(tail)] <= res_b;
    end
  end

  assign result_kind = q[head].kind;
  assign code_point  = q[head].code_point;
  assign byte_count  = q[head].byte_count;
  assign last_of_run = q[head].last;

  // a sequence never holds more bytes than its lead byte announced
  assert property (@(posedge clk) disable iff (rst)
    bytes_seen <= bytes_expected && bytes_expected <= 3'd4)
    else $error("decoder byte counts out of range");

  // an earlier result of a byte is always queued together with its final one
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run |-> count >= 2'd2)
    else $error("first of two results queued without its partner");

  // a byte that ends a sequence leaves a result waiting on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    accept && !idle && !broken && seen_inc == bytes_expected |=> out_valid)
    else $error("completed sequence gave no result");

endmodule

`default_nettype wire

@@ tb/sv/utf8_stream_decoder_validator_top_test.sv @@
// self-checking testbench for the utf-8 stream decoder and validator
`timescale 1ns / 100ps

module utf8_stream_decoder_validator_top_test;

  localparam int unsigned RANDOM_BYTES = 1650;
  localparam logic [7:0]  CONT_MAX     = 8'hBF;
  localparam logic [7:0]  LEAD4_MAX    = 8'hF4;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic        out_ready = 1'b0;
  wire logic   in_ready;
  wire logic   out_valid;
  wire logic   result_kind;
  wire logic [20:0] code_point;
  wire logic [2:0]  byte_count;
  wire logic   last_of_run;

  utf8_stream_decoder_validator_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_kind (result_kind),
    .code_point  (code_point),
    .byte_count  (byte_count),
    .last_of_run (last_of_run)
  );

  always #10 clk = ~clk;

  logic [7:0]           byte_q[$];
  utf8dv_pkg::result_t  cp_results[$];

  // decoder state as the block should hold it
  logic [utf8dv_pkg::CP_W-1:0]  dec_value = '0;
  logic [utf8dv_pkg::CNT_W-1:0] dec_len = '0;
  logic [utf8dv_pkg::CNT_W-1:0] dec_have = '0;

  int unsigned bytes_total;
  int unsigned bytes_fed;
  int unsigned bytes_loaded;
  int unsigned results_checked;
  int unsigned error_reports;
  int unsigned len_hits[1:4];
  int unsigned mismatches;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic push_result(input logic kind, input logic [utf8dv_pkg::CP_W-1:0] cp,
                             input logic [utf8dv_pkg::CNT_W-1:0] cnt);
    utf8dv_pkg::result_t r;
    r.kind       = kind;
    r.code_point = cp;
    r.byte_count = cnt;
    r.last       = 1'b0;
    cp_results.push_back(r);
  endtask

  // byte seen with no sequence open
  task automatic take_lead(input logic [7:0] c);
    if (c <= utf8dv_pkg::ASCII_MAX) begin
      dec_value = {{(utf8dv_pkg::CP_W-8){1'b0}}, c};
      dec_len   = 3'd1;
      dec_have  = 3'd1;
      push_result(utf8dv_pkg::KIND_VALID, dec_value, 3'd1);
    end else if (c >= utf8dv_pkg::LEAD_LIMIT || c == utf8dv_pkg::LEAD2_BAD ||
                 c < utf8dv_pkg::LEAD2_MIN) begin
      dec_value = '0;
      dec_len   = '0;
      dec_have  = '0;
      push_result(utf8dv_pkg::KIND_INVALID, utf8dv_pkg::REPLACEMENT_CHAR, 3'd1);
    end else begin
      dec_have = 3'd1;
      if (c >= utf8dv_pkg::LEAD4_MIN) begin
        dec_len   = 3'd4;
        dec_value = {{(utf8dv_pkg::CP_W-3){1'b0}}, c[2:0]};
      end else if (c >= utf8dv_pkg::LEAD3_MIN) begin
        dec_len   = 3'd3;
        dec_value = {{(utf8dv_pkg::CP_W-4){1'b0}}, c[3:0]};
      end else begin
        dec_len   = 3'd2;
        dec_value = {{(utf8dv_pkg::CP_W-5){1'b0}}, c[4:0]};
      end
    end
  endtask

  task automatic decode_byte(input logic [7:0] c);
    int unsigned first;
    logic        broken;
    first = cp_results.size();
    if (dec_have != dec_len) begin
      broken = (c[7:6] != 2'b10);
      if (!broken && dec_have == 3'd1) begin
        // overlong or beyond U+10FFFF, caught on the second byte
        if (dec_len == 3'd4 && dec_value == 4 && c >= utf8dv_pkg::CONT_EDGE_F)
          broken = 1'b1;
        if (dec_value == 0) begin
          if (dec_len == 3'd3 && c < utf8dv_pkg::CONT_MIN_E0) broken = 1'b1;
          if (dec_len == 3'd4 && c < utf8dv_pkg::CONT_EDGE_F) broken = 1'b1;
          if (dec_len == 3'd2 && c != utf8dv_pkg::CONT_MIN) broken = 1'b1;
        end
      end
      if (broken) begin
        push_result(utf8dv_pkg::KIND_INVALID, utf8dv_pkg::REPLACEMENT_CHAR, dec_have);
        dec_value = '0;
        dec_len   = '0;
        dec_have  = '0;
        take_lead(c);
      end else begin
        dec_value = {dec_value[utf8dv_pkg::CP_W-7:0], c[5:0]};
        dec_have  = dec_have + 3'd1;
        if (dec_have == dec_len) push_result(utf8dv_pkg::KIND_VALID, dec_value, dec_len);
      end
    end else begin
      take_lead(c);
    end
    if (cp_results.size() > first) cp_results[cp_results.size()-1].last = 1'b1;
  endtask

  // mostly back to back, a few short holds, now and then a long one
  function automatic int pick_hold(input bit steady);
    int r;
    r = $urandom_range(99);
    if (steady || r < 65) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(28, 6);
  endfunction

  // lead plus conts continuation bytes, second byte kept clear of overlong and out of range forms
  task automatic add_sequence(input int len, input int conts);
    logic [7:0] lead;
    logic [7:0] lo;
    logic [7:0] hi;
    lo = utf8dv_pkg::CONT_MIN;
    hi = CONT_MAX;
    case (len)
      2:       lead = 8'($urandom_range(8'hDF, 8'hC2));
      3:       lead = 8'($urandom_range(8'hEF, utf8dv_pkg::LEAD3_MIN));
      default: lead = 8'($urandom_range(LEAD4_MAX, utf8dv_pkg::LEAD4_MIN));
    endcase
    if (lead == utf8dv_pkg::LEAD3_MIN) lo = utf8dv_pkg::CONT_MIN_E0;
    if (lead == utf8dv_pkg::LEAD4_MIN) lo = utf8dv_pkg::CONT_EDGE_F;
    if (lead == LEAD4_MAX) hi = 8'h8F;
    byte_q.push_back(lead);
    for (int i = 0; i < conts; i++) begin
      byte_q.push_back(8'($urandom_range(hi, lo)));
      lo = utf8dv_pkg::CONT_MIN;
      hi = CONT_MAX;
    end
  endtask

  task automatic add_random_chunk();
    int r;
    int len;
    r = $urandom_range(99);
    if (r < 25) begin
      byte_q.push_back(8'($urandom_range(utf8dv_pkg::ASCII_MAX)));
    end else if (r < 70) begin
      len = (r < 40) ? 2 : (r < 55) ? 3 : 4;
      add_sequence(len, len - 1);
    end else if (r < 73) begin
      byte_q.push_back(utf8dv_pkg::LEAD2_MIN);
      byte_q.push_back(utf8dv_pkg::CONT_MIN);
    end else if (r < 85) begin
      // sequence cut short by whatever comes next
      len = $urandom_range(4, 2);
      add_sequence(len, $urandom_range(len - 2, 0));
    end else if (r < 93) begin
      byte_q.push_back(8'($urandom_range(255)));
    end else begin
      case ($urandom_range(3))
        0: begin
          byte_q.push_back(utf8dv_pkg::LEAD3_MIN);
          byte_q.push_back(8'($urandom_range(8'h9F, utf8dv_pkg::CONT_MIN)));
        end
        1: begin
          byte_q.push_back(utf8dv_pkg::LEAD4_MIN);
          byte_q.push_back(8'($urandom_range(8'h8F, utf8dv_pkg::CONT_MIN)));
        end
        2: begin
          byte_q.push_back(LEAD4_MAX);
          byte_q.push_back(8'($urandom_range(CONT_MAX, utf8dv_pkg::CONT_EDGE_F)));
        end
        default: begin
          byte_q.push_back(utf8dv_pkg::LEAD2_MIN);
          byte_q.push_back(8'($urandom_range(CONT_MAX, 8'h81)));
        end
      endcase
    end
  endtask

  // byte driver
  int  feed_gap;
  bit  feed_steady;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      feed_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        decode_byte(data_byte);
        bytes_fed++;
      end
      if (!in_valid || in_ready) begin
        if (feed_gap > 0) begin
          in_valid <= 1'b0;
          feed_gap--;
        end else if (byte_q.size() != 0) begin
          in_valid  <= 1'b1;
          data_byte <= byte_q.pop_front();
          if (bytes_loaded % 100 == 0) feed_steady = ($urandom_range(2) == 0);
          bytes_loaded++;
          feed_gap = pick_hold(feed_steady);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  int          drain_hold;
  bit          drain_steady;
  int unsigned mon_cycles;

  task automatic check_result();
    utf8dv_pkg::result_t want;
    if (cp_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind %0d cp %h cnt %0d last %0d",
                                result_kind, code_point, byte_count, last_of_run));
    end else begin
      want = cp_results.pop_front();
      if (result_kind !== want.kind || code_point !== want.code_point ||
          byte_count !== want.byte_count || last_of_run !== want.last)
        report_mismatch($sformatf(
          "result %0d: got kind %0d cp %h cnt %0d last %0d, want %0d %h %0d %0d",
          results_checked, result_kind, code_point, byte_count, last_of_run,
          want.kind, want.code_point, want.byte_count, want.last));
      if (want.kind == utf8dv_pkg::KIND_INVALID) error_reports++;
      else if (want.byte_count >= 1 && want.byte_count <= 4) len_hits[want.byte_count]++;
    end
    results_checked++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      drain_hold = 0;
    end else begin
      if (out_valid && out_ready) check_result();
      if (mon_cycles % 256 == 0) drain_steady = ($urandom_range(2) == 0);
      mon_cycles++;
      if (drain_hold > 0) begin
        out_ready <= 1'b0;
        drain_hold--;
      end else begin
        out_ready <= 1'b1;
        drain_hold = pick_hold(drain_steady);
      end
    end
  end

  initial begin
    // ascii extremes, modified nul, bad leads, stray continuation,
    // overlongs, range limit, surrogate, and a cut-off sequence
    byte_q = {8'h00, 8'h7F, 8'hC0, 8'h80, 8'hC0, 8'h81, 8'hC1, 8'hF5, 8'hFF, 8'h80,
              8'hE0, 8'hA0, 8'h80, 8'hE0, 8'h9F, 8'hED, 8'hA0, 8'h80, 8'hF0, 8'h8F,
              8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hF4, 8'h90, 8'hE2, 8'h41};
    bytes_total = byte_q.size() + RANDOM_BYTES;
    while (byte_q.size() < bytes_total) add_random_chunk();
    bytes_total = byte_q.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (bytes_fed != bytes_total) @(negedge clk);
    while (cp_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("fed %0d bytes, checked %0d results", bytes_fed, results_checked);
    $display("code points by length 1/2/3/4: %0d/%0d/%0d/%0d, error reports: %0d",
             len_hits[1], len_hits[2], len_hits[3], len_hits[4], error_reports);
    if (mismatches == 0) begin
      $display("utf8_stream_decoder_validator_top_test OK");
    end else begin
      $display("utf8_stream_decoder_validator_top_test NOT OK");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("timeout with %0d of %0d bytes fed", bytes_fed, bytes_total);
    $display("utf8_stream_decoder_validator_top_test NOT OK");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/utf8dv_pkg.sv
rtl/core/utf8_stream_decoder_validator_top.sv
tb/sv/utf8_stream_decoder_validator_top_test.sv
